FILE: hw/rtl/lsm_pkg.sv
`timescale 1ns / 1ps
package lsm_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int SAMPLE_DEPTH_DEF  = 32;
    localparam int METRIC_COUNT_DEF  = 7;
    localparam int NUM_BUDGETS       = 7;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 216;

    localparam logic [2:0] KIND_BEGIN   = 3'd0;
    localparam logic [2:0] KIND_END     = 3'd1;
    localparam logic [2:0] KIND_CANCEL  = 3'd2;
    localparam logic [2:0] KIND_RECORD  = 3'd3;
    localparam logic [2:0] KIND_SUMMARY = 3'd4;
    localparam logic [2:0] KIND_CLEAR   = 3'd5;

    localparam logic [2:0] STS_STARTED  = 3'd0;
    localparam logic [2:0] STS_RECORDED = 3'd1;
    localparam logic [2:0] STS_INVALID  = 3'd2;
    localparam logic [2:0] STS_NONMONO  = 3'd3;
    localparam logic [2:0] STS_DUP      = 3'd4;
    localparam logic [2:0] STS_FULL     = 3'd5;
    localparam logic [2:0] STS_MISSING  = 3'd6;
    localparam logic [2:0] STS_REPORTED = 3'd7;

    localparam logic [15:0] BUDGET_RESET [8] = '{
        16'd100, 16'd150, 16'd2000, 16'd80, 16'd100, 16'd2000, 16'd3000, 16'd0
    };

endpackage

FILE: hw/rtl/lsm_ram.sv
`timescale 1ns / 1ps
module lsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/latency_span_monitor_unit.sv
`timescale 1ns / 1ps
// Latency span monitor. One request is taken at a time; o_s_tready is high
// only while the sequencer is idle. Begin, end and cancel scan the span table
// one entry a cycle through its memory port; end then also writes the sample.
// A summary finds the percentiles by rank counting over the metric's sample
// memory, one read a cycle. Results are held in an output register, so a
// request may be accepted while the previous result waits.
module latency_span_monitor_unit
    import lsm_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int SAMPLE_DEPTH  = SAMPLE_DEPTH_DEF,
    parameter int METRIC_COUNT  = METRIC_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_addr,
    input  logic [15:0]           i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // metric, span_id, now_ms, duration_ms
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // kind
    input  logic [2:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // budget_ms, total_count, retained_count, p50_ms, p95_ms, p99_ms, worst_ms,
    // violation_count, passes_p95, pending_count
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // status
    output logic [2:0]            o_m_tuser
);

    localparam int P   = PENDING_DEPTH;
    localparam int S   = SAMPLE_DEPTH;
    localparam int M   = METRIC_COUNT;
    localparam int PIW = (P > 1) ? $clog2(P) : 1;
    localparam int PCW = $clog2(P + 1);
    localparam int NW  = (S > 1) ? $clog2(S) : 1;
    localparam int FW  = $clog2(S + 1);
    localparam int MIW = (M > 1) ? $clog2(M) : 1;
    localparam int SAW = ((M * S) > 1) ? $clog2(M * S) : 1;
    localparam int SPW = 64 + 3 + 31;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_END, S_RESOLVE, S_ADD,
        S_SEL_C, S_SEL_CL, S_SEL_S, S_SEL_SE, S_SEL_E, S_SEL_DONE, S_OUT
    } t_state;

    t_state r_state;

    logic [15:0]  r_budget [8];
    logic         r_valid [P];
    logic [PCW-1:0] r_count;
    logic [FW-1:0]  r_fill [M];
    logic [NW-1:0]  r_next [M];
    logic [31:0]    r_total [M];
    logic [31:0]    r_over [M];
    logic [30:0]    r_last;
    logic           r_tseen;

    logic [2:0]   r_kind;
    logic [2:0]   r_metric;
    logic [63:0]  r_id;
    logic [30:0]  r_now;
    logic [30:0]  r_dur;
    logic [MIW-1:0] r_mi;

    logic [PIW-1:0] r_idx;
    logic [PIW-1:0] r_pidx;
    logic           r_pv;
    logic           r_found;
    logic [PIW-1:0] r_fidx;
    logic           r_freef;
    logic [PIW-1:0] r_free_idx;
    logic [2:0]     r_sm;
    logic [30:0]    r_sst;

    logic [FW-1:0]  r_n;
    logic [FW-1:0]  r_j;
    logic [FW-1:0]  r_i;
    logic           r_spv;
    logic [30:0]    r_cand;
    logic [FW-1:0]  r_lt;
    logic [FW-1:0]  r_le;
    logic [FW-1:0]  r_r50;
    logic [FW-1:0]  r_r95;
    logic [FW-1:0]  r_r99;

    logic [2:0]   r_status;
    logic [15:0]  r_res_budget;
    logic [31:0]  r_res_total;
    logic [5:0]   r_res_ret;
    logic [30:0]  r_p50;
    logic [30:0]  r_p95;
    logic [30:0]  r_p99;
    logic [30:0]  r_worst;
    logic [31:0]  r_res_over;
    logic         r_pass;

    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic [2:0]            r_ouser;

    logic           span_we;
    logic [SPW-1:0] span_wdata;
    logic [SPW-1:0] span_rdata;
    logic           smp_we;
    logic [SAW-1:0] smp_waddr;
    logic [SAW-1:0] smp_raddr;
    logic [30:0]    smp_rdata;
    logic [NW-1:0]  add_slot;
    logic           span_hit;
    logic           span_free;

    logic [2:0]  in_metric;
    logic [63:0] in_id;
    logic [31:0] in_now;
    logic [31:0] in_dur;
    logic        in_metric_ok;
    logic        in_nonmono;
    logic [MIW-1:0] in_mi;

    function automatic logic [FW-1:0] f_rank(input logic [FW-1:0] n, input logic [6:0] pct);
        logic [12:0] x;
        logic [25:0] q;
        begin
            x = 13'(pct) * 13'(n) + 13'd99;
            q = 26'(x) * 26'd5243;
            f_rank = FW'(q >> 19);
        end
    endfunction

    assign in_metric    = i_s_tdata[2:0];
    assign in_id        = i_s_tdata[66:3];
    assign in_now       = i_s_tdata[98:67];
    assign in_dur       = i_s_tdata[130:99];
    assign in_metric_ok = int'(in_metric) < M;
    assign in_mi        = MIW'(in_metric);
    assign in_nonmono   = r_tseen && (in_now[30:0] < r_last);

    assign span_hit  = r_pv && r_valid[r_pidx] && (span_rdata[SPW-1:34] == r_id);
    assign span_free = r_pv && !r_valid[r_pidx];

    assign add_slot = (r_fill[r_mi] < FW'(S)) ? NW'(r_fill[r_mi]) : r_next[r_mi];

    always_comb begin
        span_we    = (r_state == S_RESOLVE) && (r_kind == KIND_BEGIN) && !r_found &&
                     (r_count < PCW'(P));
        span_wdata = {r_id, r_metric, r_now};
        smp_we     = (r_state == S_ADD);
        smp_waddr  = SAW'(int'(r_mi) * S + int'(add_slot));
        if (r_state == S_SEL_C) begin
            smp_raddr = SAW'(int'(r_mi) * S + int'(r_j));
        end else begin
            smp_raddr = SAW'(int'(r_mi) * S + int'(r_i));
        end
    end

    lsm_ram #(.WIDTH(SPW), .DEPTH(P)) u_span_ram (
        .i_clk   (i_clk),
        .i_we    (span_we),
        .i_waddr (r_free_idx),
        .i_wdata (span_wdata),
        .i_raddr (r_idx),
        .o_rdata (span_rdata)
    );

    lsm_ram #(.WIDTH(31), .DEPTH(M * S)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (smp_waddr),
        .i_wdata (r_dur),
        .i_raddr (smp_raddr),
        .o_rdata (smp_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_count  <= '0;
            r_last   <= '0;
            r_tseen  <= 1'b0;
            r_pv     <= 1'b0;
            r_spv    <= 1'b0;
            r_mi     <= '0;
            for (int k = 0; k < 8; k++) begin
                r_budget[k] <= BUDGET_RESET[k];
            end
            for (int k = 0; k < P; k++) begin
                r_valid[k] <= 1'b0;
            end
            for (int k = 0; k < M; k++) begin
                r_fill[k]  <= '0;
                r_next[k]  <= '0;
                r_total[k] <= '0;
                r_over[k]  <= '0;
            end
        end else begin
            if (i_cfg_we && (int'(i_cfg_addr) < NUM_BUDGETS)) begin
                r_budget[i_cfg_addr] <= i_cfg_wdata;
            end
            if (r_ovalid && i_m_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end

            // table scan compare, one entry per cycle
            if (span_hit && !r_found) begin
                r_found <= 1'b1;
                r_fidx  <= r_pidx;
                r_sm    <= span_rdata[33:31];
                r_sst   <= span_rdata[30:0];
            end
            if (span_free && !r_freef) begin
                r_freef    <= 1'b1;
                r_free_idx <= r_pidx;
            end
            r_pv   <= (r_state == S_SCAN);
            r_pidx <= r_idx;

            // rank counting compare
            if (r_spv) begin
                if (smp_rdata < r_cand) begin
                    r_lt <= r_lt + 1'b1;
                end
                if (smp_rdata <= r_cand) begin
                    r_le <= r_le + 1'b1;
                end
            end
            r_spv <= (r_state == S_SEL_S);

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind       <= i_s_tuser;
                        r_metric     <= in_metric;
                        r_mi         <= in_mi;
                        r_id         <= in_id;
                        r_now        <= in_now[30:0];
                        r_dur        <= in_dur[30:0];
                        r_status     <= STS_INVALID;
                        r_res_budget <= '0;
                        r_res_total  <= '0;
                        r_res_ret    <= '0;
                        r_p50        <= '0;
                        r_p95        <= '0;
                        r_p99        <= '0;
                        r_worst      <= '0;
                        r_res_over   <= '0;
                        r_pass       <= 1'b0;
                        r_found      <= 1'b0;
                        r_freef      <= 1'b0;
                        r_idx        <= '0;
                        r_state      <= S_OUT;
                        case (i_s_tuser)
                            KIND_BEGIN, KIND_END: begin
                                if ((in_id != 64'd0) && !in_now[31] &&
                                    (in_metric_ok || (i_s_tuser == KIND_END))) begin
                                    if (in_nonmono) begin
                                        r_status <= STS_NONMONO;
                                    end else begin
                                        r_last  <= in_now[30:0];
                                        r_tseen <= 1'b1;
                                        r_state <= S_SCAN;
                                    end
                                end
                            end
                            KIND_CANCEL: begin
                                if (in_id != 64'd0) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            KIND_RECORD: begin
                                if (!in_dur[31] && in_metric_ok) begin
                                    r_state <= S_ADD;
                                end
                            end
                            KIND_SUMMARY: begin
                                if (in_metric_ok) begin
                                    r_status     <= STS_REPORTED;
                                    r_res_budget <= r_budget[in_metric];
                                    if (r_fill[in_mi] != '0) begin
                                        r_n     <= r_fill[in_mi];
                                        r_r50   <= f_rank(r_fill[in_mi], 7'd50);
                                        r_r95   <= f_rank(r_fill[in_mi], 7'd95);
                                        r_r99   <= f_rank(r_fill[in_mi], 7'd99);
                                        r_j     <= '0;
                                        r_state <= S_SEL_C;
                                    end
                                end
                            end
                            KIND_CLEAR: begin
                                if (in_metric_ok) begin
                                    r_fill[in_mi]  <= '0;
                                    r_next[in_mi]  <= '0;
                                    r_total[in_mi] <= '0;
                                    r_over[in_mi]  <= '0;
                                    r_status       <= STS_RECORDED;
                                end
                            end
                            default: begin
                                r_status <= STS_INVALID;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == PIW'(P - 1)) begin
                        r_state <= S_SCAN_END;
                    end
                end
                S_SCAN_END: begin
                    r_state <= S_RESOLVE;
                end
                S_RESOLVE: begin
                    r_state <= S_OUT;
                    case (r_kind)
                        KIND_BEGIN: begin
                            if (r_found) begin
                                r_status <= STS_DUP;
                            end else if (r_count >= PCW'(P)) begin
                                r_status <= STS_FULL;
                            end else begin
                                r_valid[r_free_idx] <= 1'b1;
                                r_count  <= r_count + 1'b1;
                                r_status <= STS_STARTED;
                            end
                        end
                        default: begin
                            if (!r_found) begin
                                r_status <= STS_MISSING;
                            end else begin
                                r_valid[r_fidx] <= 1'b0;
                                r_count  <= r_count - 1'b1;
                                r_status <= STS_RECORDED;
                                if ((r_kind == KIND_END) && (int'(r_sm) < M)) begin
                                    r_mi    <= MIW'(r_sm);
                                    r_dur   <= (r_now >= r_sst) ? (r_now - r_sst) : 31'd0;
                                    r_state <= S_ADD;
                                end
                            end
                        end
                    endcase
                end
                S_ADD: begin
                    if (r_fill[r_mi] < FW'(S)) begin
                        r_fill[r_mi] <= r_fill[r_mi] + 1'b1;
                    end else begin
                        r_next[r_mi] <= (r_next[r_mi] == NW'(S - 1)) ? '0 :
                                        r_next[r_mi] + 1'b1;
                    end
                    if (r_total[r_mi] != 32'hFFFF_FFFF) begin
                        r_total[r_mi] <= r_total[r_mi] + 32'd1;
                    end
                    if ((r_dur > {15'd0, r_budget[3'(r_mi)]}) &&
                        (r_over[r_mi] != 32'hFFFF_FFFF)) begin
                        r_over[r_mi] <= r_over[r_mi] + 32'd1;
                    end
                    r_status <= STS_RECORDED;
                    r_state  <= S_OUT;
                end
                S_SEL_C: begin
                    r_state <= S_SEL_CL;
                end
                S_SEL_CL: begin
                    r_cand  <= smp_rdata;
                    r_i     <= '0;
                    r_lt    <= '0;
                    r_le    <= '0;
                    r_state <= S_SEL_S;
                end
                S_SEL_S: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == r_n - 1'b1) begin
                        r_state <= S_SEL_SE;
                    end
                end
                S_SEL_SE: begin
                    r_state <= S_SEL_E;
                end
                S_SEL_E: begin
                    // candidate holds rank r when lt < r <= le
                    if ((r_lt < r_r50) && (r_r50 <= r_le)) begin
                        r_p50 <= r_cand;
                    end
                    if ((r_lt < r_r95) && (r_r95 <= r_le)) begin
                        r_p95 <= r_cand;
                    end
                    if ((r_lt < r_r99) && (r_r99 <= r_le)) begin
                        r_p99 <= r_cand;
                    end
                    if ((r_lt < r_n) && (r_n <= r_le)) begin
                        r_worst <= r_cand;
                    end
                    r_j <= r_j + 1'b1;
                    if (r_j == r_n - 1'b1) begin
                        r_state <= S_SEL_DONE;
                    end else begin
                        r_state <= S_SEL_C;
                    end
                end
                S_SEL_DONE: begin
                    r_res_total <= r_total[r_mi];
                    r_res_over  <= r_over[r_mi];
                    r_res_ret   <= 6'(r_n);
                    r_pass      <= (r_p95 <= {15'd0, r_res_budget});
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_ouser  <= r_status;
                        r_odata  <= {5'(r_count), r_pass, r_res_over, r_worst, r_p99,
                                     r_p95, r_p50, r_res_ret, r_res_total, r_res_budget};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PCW'(P))
        else $error("open span count above table depth");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[r_mi] <= FW'(S))
        else $error("ring fill above sample depth");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        span_we |-> !r_valid[r_free_idx])
        else $error("span write over an open entry");
`endif

endmodule

FILE: tb/latency_span_monitor_checker.sv
`timescale 1ns / 1ps
module latency_span_monitor_checker
    import lsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_addr,
    input  logic [15:0]           i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [2:0]            i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic [2:0]            i_m_tuser,
    output int                    o_fail_count,
    output int                    o_pending_results
);
    localparam int NPEND = PENDING_DEPTH_DEF;
    localparam int NSAMP = SAMPLE_DEPTH_DEF;
    localparam int NMET  = METRIC_COUNT_DEF;

    typedef struct packed {
        logic [2:0]   status;
        logic [215:0] data;
    } t_lat_result;

    logic [15:0] budget [8];
    logic        sp_valid [NPEND];
    logic [63:0] sp_key [NPEND];
    logic [2:0]  sp_metric [NPEND];
    logic [31:0] sp_start [NPEND];
    logic [31:0] samples [NMET][NSAMP];
    int          fill [NMET];
    int          next_slot [NMET];
    logic [31:0] total [NMET];
    logic [31:0] over [NMET];
    logic [31:0] last_ms;
    logic        seen_ms;
    t_lat_result expected_q [$];

    function automatic int open_spans();
        int n;
        n = 0;
        for (int i = 0; i < NPEND; i++) if (sp_valid[i]) n++;
        return n;
    endfunction

    function automatic int find_id(logic [63:0] id);
        for (int i = 0; i < NPEND; i++) if (sp_valid[i] && sp_key[i] == id) return i;
        return -1;
    endfunction

    function automatic logic take_time(logic [31:0] now);
        if (seen_ms && now < last_ms) return 1'b0;
        last_ms = now;
        seen_ms = 1'b1;
        return 1'b1;
    endfunction

    function automatic void add_duration(int m, logic [31:0] d);
        if (fill[m] < NSAMP) begin
            samples[m][fill[m]] = d;
            fill[m]++;
        end else begin
            samples[m][next_slot[m]] = d;
            next_slot[m] = (next_slot[m] + 1) % NSAMP;
        end
        if (total[m] != 32'hFFFF_FFFF) total[m]++;
        if (d > {16'd0, budget[m]} && over[m] != 32'hFFFF_FFFF) over[m]++;
    endfunction

    function automatic t_lat_result predict_request(logic [2:0] kind,
                                                    logic [IN_DATA_W-1:0] d);
        t_lat_result r;
        logic [2:0]  m;
        logic [63:0] id;
        logic [31:0] now, dur, dd;
        logic [31:0] srt [NSAMP];
        logic [31:0] v, p50, p95, p99;
        int slot, n, k;
        logic        m_ok;
        m = d[2:0];
        id = d[66:3];
        now = d[98:67];
        dur = d[130:99];
        m_ok = m < NMET;
        r.status = STS_INVALID;
        r.data = '0;
        case (kind)
            KIND_BEGIN: begin
                if (id == 0 || now[31] || !m_ok) r.status = STS_INVALID;
                else if (!take_time(now)) r.status = STS_NONMONO;
                else if (find_id(id) >= 0) r.status = STS_DUP;
                else if (open_spans() >= NPEND) r.status = STS_FULL;
                else begin
                    for (int i = 0; i < NPEND; i++) if (!sp_valid[i]) begin
                        sp_valid[i] = 1'b1;
                        sp_key[i] = id;
                        sp_metric[i] = m;
                        sp_start[i] = now;
                        break;
                    end
                    r.status = STS_STARTED;
                end
            end
            KIND_END: begin
                if (id == 0 || now[31]) r.status = STS_INVALID;
                else if (!take_time(now)) r.status = STS_NONMONO;
                else begin
                    slot = find_id(id);
                    if (slot < 0) r.status = STS_MISSING;
                    else begin
                        sp_valid[slot] = 1'b0;
                        dd = now >= sp_start[slot] ? now - sp_start[slot] : 32'd0;
                        if (sp_metric[slot] < NMET) add_duration(sp_metric[slot], dd);
                        r.status = STS_RECORDED;
                    end
                end
            end
            KIND_CANCEL: begin
                if (id == 0) r.status = STS_INVALID;
                else begin
                    slot = find_id(id);
                    if (slot < 0) r.status = STS_MISSING;
                    else begin
                        sp_valid[slot] = 1'b0;
                        r.status = STS_RECORDED;
                    end
                end
            end
            KIND_RECORD: begin
                if (!dur[31] && m_ok) begin
                    add_duration(m, dur);
                    r.status = STS_RECORDED;
                end
            end
            KIND_SUMMARY: begin
                if (m_ok) begin
                    r.status = STS_REPORTED;
                    r.data[15:0] = budget[m];
                    n = fill[m];
                    if (n > 0) begin
                        for (int i = 0; i < n; i++) begin
                            v = samples[m][i];
                            k = i;
                            while (k > 0 && srt[k-1] > v) begin
                                srt[k] = srt[k-1];
                                k--;
                            end
                            srt[k] = v;
                        end
                        p50 = srt[(50 * n + 99) / 100 - 1];
                        p95 = srt[(95 * n + 99) / 100 - 1];
                        p99 = srt[(99 * n + 99) / 100 - 1];
                        r.data[47:16]   = total[m];
                        r.data[53:48]   = n[5:0];
                        r.data[84:54]   = p50[30:0];
                        r.data[115:85]  = p95[30:0];
                        r.data[146:116] = p99[30:0];
                        r.data[177:147] = srt[n-1][30:0];
                        r.data[209:178] = over[m];
                        r.data[210]     = p95 <= {16'd0, budget[m]};
                    end
                end
            end
            KIND_CLEAR: begin
                if (m_ok) begin
                    fill[m] = 0;
                    next_slot[m] = 0;
                    total[m] = 0;
                    over[m] = 0;
                    r.status = STS_RECORDED;
                end
            end
            default: r.status = STS_INVALID;
        endcase
        r.data[215:211] = 5'(open_spans());
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lat_result e;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) budget[i] <= BUDGET_RESET[i];
            for (int i = 0; i < NPEND; i++) sp_valid[i] = 1'b0;
            for (int i = 0; i < NMET; i++) begin
                fill[i] = 0;
                next_slot[i] = 0;
                total[i] = 0;
                over[i] = 0;
            end
            last_ms = 0;
            seen_ms = 1'b0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we && i_cfg_addr < NUM_BUDGETS) budget[i_cfg_addr] <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                expected_q = {expected_q, predict_request(i_s_tuser, i_s_tdata)};
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result status %0d data %h", $time,
                             i_m_tuser, i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.status !== i_m_tuser || e.data !== i_m_tdata) begin
                        $display("%0t: mismatch expected status %0d data %h", $time,
                                 e.status, e.data);
                        $display("%0t:          actual   status %0d data %h", $time,
                                 i_m_tuser, i_m_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending_results <= expected_q.size();
    end
endmodule

FILE: tb/tb_latency_span_monitor_unit.sv
`timescale 1ns / 1ps
module tb_latency_span_monitor_unit;
    import lsm_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [2:0]            i_cfg_addr;
    logic [15:0]           i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [2:0]            i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [2:0]            o_m_tuser;
    int                    fail_count;
    int                    results_due;
    int                    idle_cycles;
    bit                    calm;
    logic [63:0]           id_pool [8];

    latency_span_monitor_unit u_top (.*);

    latency_span_monitor_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .o_fail_count(fail_count),
        .o_pending_results(results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls
    always @(negedge i_clk) i_m_tready <= calm || ($urandom_range(99) >= 38);

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] kind, logic [2:0] m, logic [63:0] id,
                                logic [31:0] now, logic [31:0] dur);
        while (!calm && $urandom_range(99) < 38) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {5'd0, dur, now, id, m};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_budget(logic [2:0] idx, logic [15:0] val);
        i_s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (3000) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        logic [31:0] now;
        logic [63:0] id;
        logic [31:0] dur;
        int pick;
        now = $urandom_range(1000);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            id = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                           : id_pool[$urandom_range(7)];
            if ($urandom_range(30) == 0) now = $urandom;
            else if ($urandom_range(15) != 0) now = now + $urandom_range(3000);
            else now = now - $urandom_range(50);
            case ($urandom_range(3))
                0: dur = $urandom_range(300);
                1: dur = $urandom_range(5000);
                2: dur = $urandom >> $urandom_range(31);
                default: dur = $urandom;
            endcase
            if (pick < 28) send_request(KIND_BEGIN, 3'($urandom_range(7)), id, now, dur);
            else if (pick < 52) send_request(KIND_END, 3'($urandom_range(7)), id, now, dur);
            else if (pick < 60) send_request(KIND_CANCEL, 3'($urandom_range(7)), id, now, dur);
            else if (pick < 82) send_request(KIND_RECORD, 3'($urandom_range(7)), id, now, dur);
            else if (pick < 92) send_request(KIND_SUMMARY, 3'($urandom_range(7)), id, now, dur);
            else if (pick < 94) send_request(KIND_CLEAR, 3'($urandom_range(7)), id, now, dur);
            else if (pick < 96) send_request(3'($urandom_range(7, 6)), 3'($urandom_range(7)),
                                             id, now, dur);
            else send_request(3'($urandom_range(7)), 3'($urandom_range(7)),
                              {$urandom, $urandom}, $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        calm = 1'b0;
        for (int i = 0; i < 8; i++) id_pool[i] = 64'(i + 1);
        id_pool[6] = 64'hFFFF_FFFF_FFFF_FFFF;
        id_pool[7] = 64'h8000_0000_0000_0001;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        send_request(KIND_SUMMARY, 3'd0, 64'd0, 32'd0, 32'd0);
        send_request(KIND_BEGIN, 3'd0, 64'd0, 32'd5, 32'd0);
        send_request(KIND_BEGIN, 3'd7, 64'd1, 32'd5, 32'd0);
        send_request(KIND_BEGIN, 3'd0, 64'd1, 32'h8000_0000, 32'd0);
        send_request(KIND_BEGIN, 3'd0, 64'd1, 32'd10, 32'd0);
        send_request(KIND_BEGIN, 3'd1, 64'd1, 32'd20, 32'd0);
        send_request(KIND_BEGIN, 3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 32'd0);
        send_request(KIND_END, 3'd0, 64'd1, 32'd150, 32'd0);
        send_request(KIND_END, 3'd0, 64'd1, 32'd160, 32'd0);
        send_request(KIND_END, 3'd0, 64'd0, 32'd160, 32'd0);
        send_request(KIND_CANCEL, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0);
        send_request(KIND_CANCEL, 3'd0, 64'd0, 32'd0, 32'd0);
        send_request(KIND_CANCEL, 3'd0, 64'd9, 32'd0, 32'd0);
        send_request(KIND_RECORD, 3'd0, 64'd0, 32'd0, 32'h7FFF_FFFF);
        send_request(KIND_RECORD, 3'd0, 64'd0, 32'd0, 32'd0);
        send_request(KIND_RECORD, 3'd0, 64'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(KIND_RECORD, 3'd7, 64'd0, 32'd0, 32'd5);
        send_request(KIND_SUMMARY, 3'd0, 64'd0, 32'd0, 32'd0);
        send_request(KIND_SUMMARY, 3'd7, 64'd0, 32'd0, 32'd0);
        send_request(3'd6, 3'd0, 64'd1, 32'd0, 32'd0);
        send_request(3'd7, 3'd0, 64'd1, 32'd0, 32'd0);
        for (int i = 0; i < 17; i++) send_request(KIND_BEGIN, 3'(i % 7), 64'd100 + i,
                                                  32'd200, 32'd0);
        for (int i = 0; i < 16; i++) send_request(KIND_END, 3'd0, 64'd100 + i,
                                                  32'd250 + i, 32'd0);
        for (int i = 0; i < 40; i++) send_request(KIND_RECORD, 3'd3, 64'd0, 32'd0, i * 7);
        send_request(KIND_SUMMARY, 3'd3, 64'd0, 32'd0, 32'd0);
        send_request(KIND_CLEAR, 3'd3, 64'd0, 32'd0, 32'd0);
        send_request(KIND_CLEAR, 3'd7, 64'd0, 32'd0, 32'd0);
        send_request(KIND_SUMMARY, 3'd3, 64'd0, 32'd0, 32'd0);

        // budget extremes, random settings, then swapped extremes, each with random traffic
        for (int i = 0; i < 7; i++) set_budget(3'(i), (i % 2) ? 16'hFFFF : 16'h0000);
        random_phase(450);
        calm = 1'b1;
        random_phase(250);
        calm = 1'b0;
        for (int i = 0; i < 7; i++) set_budget(3'(i), 16'($urandom_range(6000)));
        random_phase(450);
        for (int i = 0; i < 7; i++) set_budget(3'(i), (i % 2) ? 16'h0000 : 16'hFFFF);
        random_phase(450);

        i_s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (3000) @(negedge i_clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
